// ===== rtl/fswtt_pkg.sv =====
// Shared types, widths and codes for the foot switch tap tempo and mode control.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package fswtt_pkg;

  localparam int CNT_W_DEF  = 24;
  localparam int OUT_W      = 24;
  localparam int PRESS_W    = 16;
  localparam int LONG3_W    = 18;
  localparam int TAP_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int MODE_W     = 2;

  localparam logic [PRESS_W-1:0] SHORT_RST   = 16'd40;
  localparam logic [PRESS_W-1:0] LONG_RST    = 16'd3000;
  localparam logic [LONG3_W-1:0] LONG3_RST   = 18'd9000;
  localparam logic [TAP_W-1:0]   TAP_MIN_RST = 20'd300;
  localparam logic [TAP_W-1:0]   TAP_MAX_RST = 20'd6000;

  localparam logic [MODE_W-1:0] CODE_NORMAL = 2'd0;
  localparam logic [MODE_W-1:0] CODE_TAP    = 2'd1;
  localparam logic [MODE_W-1:0] CODE_TUNER  = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHORT_PRESS = 3'd0,
    REG_LONG_PRESS  = 3'd1,
    REG_TAP_MIN     = 3'd2,
    REG_TAP_MAX     = 3'd3,
    REG_TAP_EN      = 3'd4,
    REG_TUNER_EN    = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'b001,
    MODE_TAP    = 3'b010,
    MODE_TUNER  = 3'b100
  } mode_t;

  typedef struct packed {
    logic [PRESS_W-1:0] short_ticks;
    logic [PRESS_W-1:0] long_ticks;
    logic [LONG3_W-1:0] long3_ticks;
    logic [TAP_W-1:0]   tap_min;
    logic [TAP_W-1:0]   tap_max;
    logic               tap_en;
    logic               tuner_en;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] op_mode;
    logic              effect_enabled;
    logic [OUT_W-1:0]  tap_interval;
    logic              mute_pulse;
    logic [OUT_W-1:0]  ticks_since_mark;
  } res_t;

  function automatic logic [MODE_W-1:0] mode_code(mode_t m);
    logic [MODE_W-1:0] c;
    c = CODE_TUNER;
    if (m == MODE_NORMAL) begin
      c = CODE_NORMAL;
    end else if (m == MODE_TAP) begin
      c = CODE_TAP;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/footswitch_tap_tempo_mode_control.sv =====
// Top level of the foot switch tap tempo and mode control.
// Depends on fswtt_pkg, fswtt_cfg, fswtt_core and fswtt_obuf.
//
// Each transfer on the input channel is one tick (one audio block) with the foot switch
// level, and produces exactly one result transfer with the mode, effect state, accepted
// tap interval, tuner mute pulse and ticks since the last mark. The state update is a
// single pass of compare and increment logic from the state registers into a two-entry
// result buffer, so a new tick is accepted every cycle as long as the result side keeps
// up; in_ready drops only when both buffer entries are full. Intervals and press lengths
// are counted in ticks, with COUNT_WIDTH-bit saturating counters. Configuration writes
// take effect at once and are meant to happen while idle.
`timescale 1ns / 1ps
`default_nettype none

module footswitch_tap_tempo_mode_control #(
  parameter int COUNT_WIDTH = fswtt_pkg::CNT_W_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst,
  input  wire                                     wr_en,
  input  wire  [fswtt_pkg::CFG_IDX_W-1:0]         wr_index,
  input  wire  [fswtt_pkg::CFG_DATA_W-1:0]        wr_data,
  input  wire                                     in_valid,
  output logic                                    in_ready,
  input  wire                                     foot_pressed,
  output logic                                    out_valid,
  input  wire                                     out_ready,
  output logic [fswtt_pkg::MODE_W-1:0]            op_mode,
  output logic                                    effect_enabled,
  output logic [fswtt_pkg::OUT_W-1:0]             tap_interval,
  output logic                                    mute_pulse,
  output logic [fswtt_pkg::OUT_W-1:0]             ticks_since_mark
);
  import fswtt_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t out_res;
  logic accept;

  assign accept = in_valid && in_ready;

  fswtt_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  fswtt_core #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .foot_pressed (foot_pressed),
    .cfg          (cfg),
    .res          (core_res)
  );

  fswtt_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (core_res),
    .can_push  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_res)
  );

  assign op_mode          = out_res.op_mode;
  assign effect_enabled   = out_res.effect_enabled;
  assign tap_interval     = out_res.tap_interval;
  assign mute_pulse       = out_res.mute_pulse;
  assign ticks_since_mark = out_res.ticks_since_mark;

  a_full_has_output: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("Result buffer is full while no result is offered.");

  a_accept_gives_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("An accepted tick left no result to offer.");

  a_mute_in_tuner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mute_pulse) |-> (op_mode == CODE_TUNER))
    else $error("Mute pulse outside tuner entry.");

  a_normal_no_interval: assert property (@(posedge clk) disable iff (rst)
    (out_valid && op_mode == CODE_NORMAL) |-> (tap_interval == '0))
    else $error("Tap interval held in normal mode.");

endmodule

`default_nettype wire

// ===== rtl/fswtt_cfg.sv =====
// Configuration register file of the tap tempo and mode control.
// Depends on fswtt_pkg; also keeps three times the long threshold ready.
`timescale 1ns / 1ps
`default_nettype none

module fswtt_cfg (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                wr_en,
  input  wire  [fswtt_pkg::CFG_IDX_W-1:0]    wr_index,
  input  wire  [fswtt_pkg::CFG_DATA_W-1:0]   wr_data,
  output fswtt_pkg::cfg_t                    cfg
);
  import fswtt_pkg::*;

  cfg_t regs;
  logic [PRESS_W-1:0] wr_long;

  assign wr_long = wr_data[PRESS_W-1:0];
  assign cfg = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.short_ticks <= SHORT_RST;
      regs.long_ticks  <= LONG_RST;
      regs.long3_ticks <= LONG3_RST;
      regs.tap_min     <= TAP_MIN_RST;
      regs.tap_max     <= TAP_MAX_RST;
      regs.tap_en      <= 1'b1;
      regs.tuner_en    <= 1'b1;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        REG_SHORT_PRESS: regs.short_ticks <= wr_data[PRESS_W-1:0];
        REG_LONG_PRESS: begin
          regs.long_ticks  <= wr_long;
          regs.long3_ticks <= LONG3_W'(wr_long) + LONG3_W'({wr_long, 1'b0});
        end
        REG_TAP_MIN:  regs.tap_min  <= wr_data[TAP_W-1:0];
        REG_TAP_MAX:  regs.tap_max  <= wr_data[TAP_W-1:0];
        REG_TAP_EN:   regs.tap_en   <= wr_data[0];
        REG_TUNER_EN: regs.tuner_en <= wr_data[0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fswtt_core.sv =====
// Per-tick state update: press and elapsed counters, mode, effect and intervals.
// Depends on fswtt_pkg; the result is formed combinationally from the next state.
`timescale 1ns / 1ps
`default_nettype none

module fswtt_core #(
  parameter int COUNT_WIDTH = fswtt_pkg::CNT_W_DEF
) (
  input  wire              clk,
  input  wire              rst,
  input  wire              accept,
  input  wire              foot_pressed,
  input  fswtt_pkg::cfg_t  cfg,
  output fswtt_pkg::res_t  res
);
  import fswtt_pkg::*;

  localparam int CMP_W = (COUNT_WIDTH > TAP_W) ? COUNT_WIDTH : TAP_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] press_length, press_length_next;
  logic [COUNT_WIDTH-1:0] elapsed_ticks, elapsed_ticks_next;
  mode_t                  mode_reg, mode_reg_next;
  logic                   effect_on_reg, effect_on_reg_next;
  logic [COUNT_WIDTH-1:0] captured_interval, captured_interval_next;
  logic [TAP_W-1:0]       accepted_interval, accepted_interval_next;
  logic                   mute;

  logic [COUNT_WIDTH-1:0] elapsed_inc, press_inc;
  logic [COUNT_WIDTH-1:0] short_ext, long_ext, long3_ext;
  logic                   in_bounds;
  logic [OUT_W-1:0]       ticks_out;

  assign elapsed_inc = (elapsed_ticks == CNT_MAX) ? elapsed_ticks : elapsed_ticks + 1'b1;
  assign press_inc   = (press_length == CNT_MAX) ? press_length : press_length + 1'b1;
  assign short_ext   = COUNT_WIDTH'(cfg.short_ticks);
  assign long_ext    = COUNT_WIDTH'(cfg.long_ticks);
  assign long3_ext   = COUNT_WIDTH'(cfg.long3_ticks);
  assign in_bounds   = (CMP_W'(cfg.tap_min) < CMP_W'(captured_interval)) &&
                       (CMP_W'(captured_interval) < CMP_W'(cfg.tap_max));

  always_comb begin
    press_length_next      = press_length;
    elapsed_ticks_next     = elapsed_inc;
    mode_reg_next          = mode_reg;
    effect_on_reg_next     = effect_on_reg;
    captured_interval_next = captured_interval;
    accepted_interval_next = accepted_interval;
    mute                   = 1'b0;
    if (foot_pressed) begin
      press_length_next = press_inc;
      if (mode_reg == MODE_TAP && press_inc == short_ext) begin
        captured_interval_next = elapsed_inc;
        elapsed_ticks_next     = '0;
      end
      if (press_inc == long_ext) begin
        if (mode_reg == MODE_NORMAL) begin
          if (cfg.tap_en) begin
            mode_reg_next      = MODE_TAP;
            elapsed_ticks_next = '0;
          end
        end else begin
          mode_reg_next          = MODE_NORMAL;
          accepted_interval_next = '0;
        end
      end
      if (press_inc == long3_ext && mode_reg_next == MODE_TAP && cfg.tuner_en) begin
        mode_reg_next = MODE_TUNER;
        mute          = 1'b1;
      end
    end else begin
      if (press_length >= short_ext && press_length < long_ext) begin
        if (mode_reg == MODE_NORMAL) begin
          effect_on_reg_next = ~effect_on_reg;
        end else if (mode_reg == MODE_TAP) begin
          accepted_interval_next = in_bounds ? TAP_W'(captured_interval) : '0;
        end
      end
      press_length_next = '0;
    end
  end

  generate
    if (COUNT_WIDTH > OUT_W) begin : g_sat
      assign ticks_out = (|elapsed_ticks_next[COUNT_WIDTH-1:OUT_W]) ? '1 :
                         elapsed_ticks_next[OUT_W-1:0];
    end else begin : g_ext
      assign ticks_out = OUT_W'(elapsed_ticks_next);
    end
  endgenerate

  assign res.op_mode          = mode_code(mode_reg_next);
  assign res.effect_enabled   = effect_on_reg_next;
  assign res.tap_interval     = OUT_W'(accepted_interval_next);
  assign res.mute_pulse       = mute;
  assign res.ticks_since_mark = ticks_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_length      <= '0;
      elapsed_ticks     <= '0;
      mode_reg          <= MODE_NORMAL;
      effect_on_reg     <= 1'b0;
      captured_interval <= '0;
      accepted_interval <= '0;
    end else if (accept) begin
      press_length      <= press_length_next;
      elapsed_ticks     <= elapsed_ticks_next;
      mode_reg          <= mode_reg_next;
      effect_on_reg     <= effect_on_reg_next;
      captured_interval <= captured_interval_next;
      accepted_interval <= accepted_interval_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/fswtt_obuf.sv =====
// Two-entry result buffer: an output register with a skid register behind it.
// Depends on fswtt_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module fswtt_obuf (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  fswtt_pkg::res_t  push_data,
  output logic             can_push,
  output logic             out_valid,
  input  wire              out_ready,
  output fswtt_pkg::res_t  out_data
);
  import fswtt_pkg::*;

  res_t skid_data;
  logic skid_valid;
  logic pop;

  assign pop      = out_valid && out_ready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (!out_valid || pop) begin
        out_data <= push_data;
      end else begin
        skid_data <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for footswitch_tap_tempo_mode_control.
// Drives foot switch ticks over valid/ready, predicts every result in place and
// compares it as a whole, reporting a mismatch field by field; depends on fswtt_pkg and the RTL only.
`timescale 1ns / 1ps

module tb_top;
  import fswtt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int NUM_PHASES  = 24;
  localparam int PHASE_TICKS = 64;
  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 40;
  localparam logic [OUT_W-1:0] CNT_TOP = '1;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_B = 3'd7;

  localparam res_t NO_RES = '0;
  localparam res_t IDLE_1 = '{CODE_NORMAL, 1'b0, 24'd0, 1'b0, 24'd1};
  localparam res_t HELD_2 = '{CODE_NORMAL, 1'b0, 24'd0, 1'b0, 24'd2};
  localparam res_t FREE_3 = '{CODE_NORMAL, 1'b0, 24'd0, 1'b0, 24'd3};

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct {
    row_kind_t              kind;
    logic                   lvl;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]  data;
    bit                     typed;
    res_t                   res;
  } dir_row_t;

  logic                   clk;
  logic                   rst;
  logic                   wr_en;
  logic [CFG_IDX_W-1:0]   wr_index;
  logic [CFG_DATA_W-1:0]  wr_data;
  logic                   in_valid;
  logic                   in_ready;
  logic                   foot_pressed;
  logic                   out_valid;
  logic                   out_ready;
  logic [MODE_W-1:0]      op_mode;
  logic                   effect_enabled;
  logic [OUT_W-1:0]       tap_interval;
  logic                   mute_pulse;
  logic [OUT_W-1:0]       ticks_since_mark;

  // Predicted state of the switch logic and its register copy.
  logic [OUT_W-1:0]    press_len;
  logic [OUT_W-1:0]    since_mark;
  logic [MODE_W-1:0]   mode_q;
  logic                effect_q;
  logic [OUT_W-1:0]    captured;
  logic [OUT_W-1:0]    accepted;
  logic [PRESS_W-1:0]  lim_short;
  logic [PRESS_W-1:0]  lim_long;
  logic [TAP_W-1:0]    lim_tmin;
  logic [TAP_W-1:0]    lim_tmax;
  logic                tap_allow;
  logic                tuner_allow;

  res_t        exp_results[$];
  dir_row_t    dir_rows [0:29];
  int          err_count;
  int          ticks_sent;
  int          tuner_entries;
  int          intervals_taken;
  int          hold_requests;
  int unsigned cycle_cnt;
  wire         calm = (cycle_cnt >= 32'd1200) && (cycle_cnt < 32'd2400);

  footswitch_tap_tempo_mode_control i_dut (
    .clk              (clk),
    .rst              (rst),
    .wr_en            (wr_en),
    .wr_index         (wr_index),
    .wr_data          (wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .foot_pressed     (foot_pressed),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .op_mode          (op_mode),
    .effect_enabled   (effect_enabled),
    .tap_interval     (tap_interval),
    .mute_pulse       (mute_pulse),
    .ticks_since_mark (ticks_since_mark)
  );

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_cnt, exp_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic advance_switch(input logic held, output res_t r);
    logic [OUT_W-1:0] long3;
    logic             mute;
    long3 = OUT_W'(lim_long) * OUT_W'(3);
    mute  = 1'b0;
    if (since_mark != CNT_TOP) since_mark++;
    if (held) begin
      if (press_len != CNT_TOP) press_len++;
      if (mode_q == CODE_TAP && press_len == OUT_W'(lim_short)) begin
        captured   = since_mark;
        since_mark = '0;
      end
      if (press_len == OUT_W'(lim_long)) begin
        if (mode_q == CODE_NORMAL) begin
          if (tap_allow) begin
            mode_q     = CODE_TAP;
            since_mark = '0;
          end
        end else begin
          mode_q   = CODE_NORMAL;
          accepted = '0;
        end
      end
      if (press_len == long3 && mode_q == CODE_TAP && tuner_allow) begin
        mode_q = CODE_TUNER;
        mute   = 1'b1;
        tuner_entries++;
      end
    end else begin
      if (press_len >= OUT_W'(lim_short) && press_len < OUT_W'(lim_long)) begin
        if (mode_q == CODE_NORMAL) begin
          effect_q = ~effect_q;
        end else if (mode_q == CODE_TAP) begin
          if (OUT_W'(lim_tmin) < captured && captured < OUT_W'(lim_tmax)) begin
            accepted = captured;
            if (captured != '0) intervals_taken++;
          end else begin
            accepted = '0;
          end
        end
      end
      press_len = '0;
    end
    r = {mode_q, effect_q, accepted, mute, since_mark};
  endtask

  task automatic send_tick(input logic lvl, input bit typed, input res_t typed_res);
    res_t want;
    if (!calm && $urandom_range(0, 99) < 16) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    foot_pressed <= lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
    advance_switch(lvl, want);
    exp_results.push_back(typed ? typed_res : want);
    ticks_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (exp_results.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SHORT_PRESS: lim_short   = data[PRESS_W-1:0];
      REG_LONG_PRESS:  lim_long    = data[PRESS_W-1:0];
      REG_TAP_MIN:     lim_tmin    = data;
      REG_TAP_MAX:     lim_tmax    = data;
      REG_TAP_EN:      tap_allow   = data[0];
      REG_TUNER_EN:    tuner_allow = data[0];
      default: ;
    endcase
    wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin : receiver
    int hold_left;
    int hold_served;
    hold_left   = 0;
    hold_served = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_served) begin
        hold_served = hold_requests;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(0, 99) >= 24);
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (!rst && out_valid === 1'b1 && out_ready === 1'b1) begin
      got = {op_mode, effect_enabled, tap_interval, mute_pulse, ticks_since_mark};
      if (exp_results.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS) begin
          $display("%0t: result transfer with nothing expected, actual %h", $time, got);
        end
      end else begin
        want = exp_results.pop_front();
        if (got !== want) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: expected mode %0d effect %0b interval %0d mute %0b ticks %0d",
                     $time, want.op_mode, want.effect_enabled, want.tap_interval,
                     want.mute_pulse, want.ticks_since_mark);
            $display("%0t: actual   mode %0d effect %0b interval %0d mute %0b ticks %0d",
                     $time, got.op_mode, got.effect_enabled, got.tap_interval,
                     got.mute_pulse, got.ticks_since_mark);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int sp;
    int lp;
    int tmin;
    int tmax;
    int plen;
    int gap;
    int goal;
    bit ten;
    bit tuen;

    rst          <= 1'b1;
    in_valid     <= 1'b0;
    foot_pressed <= 1'b0;
    wr_en        <= 1'b0;
    wr_index     <= REG_SHORT_PRESS;
    wr_data      <= '0;
    press_len    = '0;
    since_mark   = '0;
    mode_q       = CODE_NORMAL;
    effect_q     = 1'b0;
    captured     = '0;
    accepted     = '0;
    lim_short    = SHORT_RST;
    lim_long     = LONG_RST;
    lim_tmin     = TAP_MIN_RST;
    lim_tmax     = TAP_MAX_RST;
    tap_allow    = 1'b1;
    tuner_allow  = 1'b1;

    dir_rows = '{
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b1, IDLE_1},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b1, HELD_2},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b1, FREE_3},
      '{ROW_WRITE, 1'b0, REG_SHORT_PRESS, 20'd1,       1'b0, NO_RES},
      '{ROW_WRITE, 1'b0, REG_LONG_PRESS,  20'd2,       1'b0, NO_RES},
      '{ROW_WRITE, 1'b0, REG_TAP_MIN,     20'd0,       1'b0, NO_RES},
      '{ROW_WRITE, 1'b0, REG_TAP_MAX,     20'hFFFFF,   1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b1, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES},
      '{ROW_TICK,  1'b0, REG_SHORT_PRESS, 20'd0,       1'b0, NO_RES}
    };

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // The directed rows walk through a toggle, tap entry, a capture and its acceptance,
    // tap back to normal, tuner entry within one press, a tuner release and tuner exit.
    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WRITE) begin
        drain_results();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        send_tick(dir_rows[i].lvl, dir_rows[i].typed, dir_rows[i].res);
      end
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      drain_results();
      sp   = $urandom_range(1, 4);
      lp   = sp + $urandom_range(1, 8);
      tmin = $urandom_range(0, 15);
      tmax = tmin + $urandom_range(1, 40);
      ten  = ($urandom_range(0, 9) != 0);
      tuen = ($urandom_range(0, 9) != 0);
      case (phase % 8)
        1: sp = 0;
        3: begin
          lp   = 0;
          tmax = 0;
        end
        5: sp = lp + $urandom_range(0, 3);
        7: begin
          sp   = 16'hFFFF;
          lp   = 16'hFFFF;
          tmin = 20'hFFFFF;
          tmax = 20'hFFFFF;
        end
        default: ;
      endcase
      if (phase == 2) begin
        ten  = 1'b0;
        tuen = 1'b0;
      end
      if (phase == 4) begin
        ten  = 1'b1;
        tuen = 1'b0;
      end
      write_reg(REG_SHORT_PRESS, {4'($urandom_range(0, 15)), 16'(sp)});
      write_reg(REG_LONG_PRESS, {4'($urandom_range(0, 15)), 16'(lp)});
      write_reg(REG_TAP_MIN, 20'(tmin));
      write_reg(REG_TAP_MAX, 20'(tmax));
      write_reg(REG_TAP_EN, {19'($urandom), ten});
      write_reg(REG_TUNER_EN, {19'($urandom), tuen});
      if (phase == 6) begin
        write_reg(IDX_SPARE_A, 20'($urandom));
        write_reg(IDX_SPARE_B, 20'($urandom));
      end
      if (phase == 10) hold_requests++;

      goal = ticks_sent + PHASE_TICKS;
      while (ticks_sent < goal) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) send_tick(1'($urandom_range(0, 1)), 1'b0, NO_RES);
        end else begin
          case ($urandom_range(0, 7))
            0: plen = sp - 1;
            1: plen = sp;
            2: plen = (lp > sp) ? $urandom_range(sp, lp - 1) : sp;
            3: plen = lp;
            4: plen = lp + $urandom_range(1, 3);
            5: plen = 3 * lp;
            6: plen = 3 * lp + $urandom_range(1, 2);
            default: plen = $urandom_range(1, 3 * lp + 2);
          endcase
          if (plen < 1) plen = 1;
          if (plen > 64) plen = $urandom_range(1, 64);
          gap = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 12);
          repeat (plen) send_tick(1'b1, 1'b0, NO_RES);
          repeat (gap) send_tick(1'b0, 1'b0, NO_RES);
        end
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    $display("Checked %0d ticks over %0d register settings with %0d tuner entries,",
             ticks_sent, NUM_PHASES + 2, tuner_entries);
    $display("%0d tap intervals taken, random gaps on both sides and one long output stall.",
             intervals_taken);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== footswitch_tap_tempo_mode_control.f =====
rtl/fswtt_pkg.sv
rtl/fswtt_cfg.sv
rtl/fswtt_core.sv
rtl/fswtt_obuf.sv
rtl/footswitch_tap_tempo_mode_control.sv
tb/tb_top.sv
